// File: hw/rtl/dbpd_pkg.sv
// Shared constants and types for the double bottom pattern detector.
package dbpd_pkg;

   // Configuration register file
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CFG_WIDTH       = 17;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEPTH_TOLERANCE = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PEAK_MARGIN     = 1'b1;

   localparam logic [CFG_WIDTH-1:0] DEPTH_TOLERANCE_RESET = 17'd1966;
   localparam logic [CFG_WIDTH-1:0] PEAK_MARGIN_RESET     = 17'd67502;

   // Fraction bits of the Q16 ratios
   localparam int FRAC_BITS = 16;

   // Job queue between front and back
   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_WIDTH = 2;

   // Per-job control flags
   typedef struct packed {
      logic compare;      // a valley pair needs the depth and peak tests
      logic last;         // item closes the series, a result is due
      logic long_enough;  // series reached the minimum sample count
   } job_flags_type;

   // Queue fill status
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// File: hw/rtl/dbpd_front.sv
// Front end: tracks the sample window, finds valleys and issues test jobs.
module dbpd_front #(
   parameter int PRICE_WIDTH = 32,
   parameter int MIN_SAMPLES = 6
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        item_accept,
   input  logic [PRICE_WIDTH-1:0]      sample_price,
   input  logic                        last_sample,
   output logic                        job_push,
   output dbpd_pkg::job_flags_type     job_flags,
   output logic [PRICE_WIDTH-1:0]      job_valley_old,
   output logic [PRICE_WIDTH-1:0]      job_valley_new,
   output logic [PRICE_WIDTH-1:0]      job_peak
);
   import dbpd_pkg::*;

   localparam int CNT_WIDTH = $clog2(MIN_SAMPLES + 1);

   logic [PRICE_WIDTH-1:0] older_ff, older_in;
   logic [PRICE_WIDTH-1:0] newer_ff, newer_in;
   logic [CNT_WIDTH-1:0]   count_ff, count_in;
   logic                   valley_seen_ff, valley_seen_in;
   logic [PRICE_WIDTH-1:0] valley_price_ff, valley_price_in;
   logic [PRICE_WIDTH-1:0] peak_ff, peak_in;

   logic                   is_valley;
   logic [PRICE_WIDTH-1:0] peak_now;
   logic [CNT_WIDTH-1:0]   count_next;

   // Classify the middle sample of the window
   always_comb begin
      is_valley = (count_ff >= CNT_WIDTH'(2)) && (newer_ff < older_ff) &&
                  (newer_ff < sample_price);
      peak_now  = peak_ff;
      if ((count_ff >= CNT_WIDTH'(2)) && valley_seen_ff && (newer_ff > peak_ff)) begin
         peak_now = newer_ff;
      end
      count_next = (count_ff < CNT_WIDTH'(MIN_SAMPLES)) ? count_ff + CNT_WIDTH'(1)
                                                        : count_ff;
   end

   // Issue a job for each valley pair and for each series end
   always_comb begin
      job_flags.compare     = is_valley && valley_seen_ff;
      job_flags.last        = last_sample;
      job_flags.long_enough = (count_next >= CNT_WIDTH'(MIN_SAMPLES));
      job_push              = item_accept && (job_flags.compare || last_sample);
      job_valley_old        = valley_price_ff;
      job_valley_new        = newer_ff;
      job_peak              = peak_now;
   end

   // Advance the window, or drop it at the end of a series
   always_comb begin
      older_in        = older_ff;
      newer_in        = newer_ff;
      count_in        = count_ff;
      valley_seen_in  = valley_seen_ff;
      valley_price_in = valley_price_ff;
      peak_in         = peak_ff;
      if (item_accept) begin
         if (last_sample) begin
            older_in        = '0;
            newer_in        = '0;
            count_in        = '0;
            valley_seen_in  = 1'b0;
            valley_price_in = '0;
            peak_in         = '0;
         end else begin
            older_in = newer_ff;
            newer_in = sample_price;
            count_in = count_next;
            if (is_valley) begin
               valley_seen_in  = 1'b1;
               valley_price_in = newer_ff;
               peak_in         = sample_price;
            end else begin
               peak_in = peak_now;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         older_ff        <= '0;
         newer_ff        <= '0;
         count_ff        <= '0;
         valley_seen_ff  <= 1'b0;
         valley_price_ff <= '0;
         peak_ff         <= '0;
      end else begin
         older_ff        <= older_in;
         newer_ff        <= newer_in;
         count_ff        <= count_in;
         valley_seen_ff  <= valley_seen_in;
         valley_price_ff <= valley_price_in;
         peak_ff         <= peak_in;
      end
   end

endmodule

// File: hw/rtl/dbpd_queue.sv
// Short job queue that decouples the front end from the test pipeline.
module dbpd_queue #(
   parameter int WIDTH = 99
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  logic [WIDTH-1:0]              push_data,
   input  logic                          pop,
   output logic [WIDTH-1:0]              head_data,
   output dbpd_pkg::queue_status_type    status
);
   import dbpd_pkg::*;

   localparam logic [QUEUE_PTR_WIDTH:0] PTR_STEP = {{QUEUE_PTR_WIDTH{1'b0}}, 1'b1};

   logic [WIDTH-1:0]         entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH:0] rd_ptr_ff, rd_ptr_in;
   logic                     do_push;
   logic                     do_pop;

   // Fill status from the wrap bit and the index bits
   always_comb begin
      status.empty = (wr_ptr_ff == rd_ptr_ff);
      status.full  = (wr_ptr_ff[QUEUE_PTR_WIDTH] != rd_ptr_ff[QUEUE_PTR_WIDTH]) &&
                     (wr_ptr_ff[QUEUE_PTR_WIDTH-1:0] == rd_ptr_ff[QUEUE_PTR_WIDTH-1:0]);
      do_push      = push && !status.full;
      do_pop       = pop && !status.empty;
      wr_ptr_in    = do_push ? wr_ptr_ff + PTR_STEP : wr_ptr_ff;
      rd_ptr_in    = do_pop ? rd_ptr_ff + PTR_STEP : rd_ptr_ff;
      head_data    = entry_ff[rd_ptr_ff[QUEUE_PTR_WIDTH-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   // Store the job at the write slot
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff[QUEUE_PTR_WIDTH-1:0]] <= push_data;
      end
   end

endmodule

// File: hw/rtl/dbpd_back.sv
// Back end: depth and peak tests as products, pattern flag and result register.
module dbpd_back #(
   parameter int PRICE_WIDTH = 32
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_write_enable,
   input  logic [dbpd_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [dbpd_pkg::CFG_WIDTH-1:0]          csr_write_data,
   input  dbpd_pkg::queue_status_type              queue_status,
   input  dbpd_pkg::job_flags_type                 head_flags,
   input  logic [PRICE_WIDTH-1:0]                  head_valley_old,
   input  logic [PRICE_WIDTH-1:0]                  head_valley_new,
   input  logic [PRICE_WIDTH-1:0]                  head_peak,
   output logic                                    pop,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic                                    rsp_bullish
);
   import dbpd_pkg::*;

   localparam int PROD_WIDTH = PRICE_WIDTH + CFG_WIDTH;

   logic [CFG_WIDTH-1:0]   depth_tol_ff, depth_tol_in;
   logic [CFG_WIDTH-1:0]   peak_margin_ff, peak_margin_in;

   logic                   advance;
   logic                   new_is_lower;
   logic [PRICE_WIDTH-1:0] high_valley;
   logic [PRICE_WIDTH-1:0] valley_diff;

   logic                   s1_valid_ff, s1_valid_in;
   job_flags_type          s1_flags_ff;
   logic [PRICE_WIDTH-1:0] s1_high_ff;
   logic [PRICE_WIDTH-1:0] s1_diff_ff;
   logic [PRICE_WIDTH-1:0] s1_peak_ff;

   logic                   s2_valid_ff, s2_valid_in;
   job_flags_type          s2_flags_ff;
   logic [PROD_WIDTH-1:0]  s2_depth_prod_ff, s2_depth_prod_in;
   logic [PROD_WIDTH-1:0]  s2_peak_prod_ff, s2_peak_prod_in;
   logic [PRICE_WIDTH-1:0] s2_diff_ff;
   logic [PRICE_WIDTH-1:0] s2_peak_ff;

   logic                   depth_ok;
   logic                   peak_ok;
   logic                   found_now;
   logic                   found_ff, found_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_bullish_ff, rsp_bullish_in;

   // Write configuration registers
   always_comb begin
      depth_tol_in   = depth_tol_ff;
      peak_margin_in = peak_margin_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_DEPTH_TOLERANCE: depth_tol_in   = csr_write_data;
            CSR_PEAK_MARGIN:     peak_margin_in = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_tol_ff   <= DEPTH_TOLERANCE_RESET;
         peak_margin_ff <= PEAK_MARGIN_RESET;
      end else begin
         depth_tol_ff   <= depth_tol_in;
         peak_margin_ff <= peak_margin_in;
      end
   end

   // Move the whole pipe whenever the result register is free or drained
   always_comb begin
      advance = !rsp_valid_ff || rsp_ready;
      pop     = advance && !queue_status.empty;
   end

   // Stage 1: higher valley and valley difference
   always_comb begin
      new_is_lower = head_valley_old > head_valley_new;
      high_valley  = new_is_lower ? head_valley_old : head_valley_new;
      valley_diff  = new_is_lower ? head_valley_old - head_valley_new
                                  : head_valley_new - head_valley_old;
      s1_valid_in  = advance ? !queue_status.empty : s1_valid_ff;
   end

   // Stage 2: scale the higher valley by both ratios
   always_comb begin
      s2_valid_in      = advance ? s1_valid_ff : s2_valid_ff;
      s2_depth_prod_in = PROD_WIDTH'(s1_high_ff) * PROD_WIDTH'(depth_tol_ff);
      s2_peak_prod_in  = PROD_WIDTH'(s1_high_ff) * PROD_WIDTH'(peak_margin_ff);
   end

   // Stage 3: compare, fold into the pattern flag, emit at series end
   always_comb begin
      depth_ok = PROD_WIDTH'({s2_diff_ff, {FRAC_BITS{1'b0}}}) <= s2_depth_prod_ff;
      peak_ok  = s2_peak_prod_ff <= PROD_WIDTH'({s2_peak_ff, {FRAC_BITS{1'b0}}});
      found_now = found_ff || (s2_flags_ff.compare && depth_ok && peak_ok);

      found_in       = found_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_bullish_in = rsp_bullish_ff;
      if (advance) begin
         rsp_valid_in = 1'b0;
         if (s2_valid_ff) begin
            if (s2_flags_ff.last) begin
               rsp_valid_in   = 1'b1;
               rsp_bullish_in = found_now && s2_flags_ff.long_enough;
               found_in       = 1'b0;
            end else begin
               found_in = found_now;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers hold while stalled
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_flags_ff      <= head_flags;
         s1_high_ff       <= high_valley;
         s1_diff_ff       <= valley_diff;
         s1_peak_ff       <= head_peak;
         s2_flags_ff      <= s1_flags_ff;
         s2_depth_prod_ff <= s2_depth_prod_in;
         s2_peak_prod_ff  <= s2_peak_prod_in;
         s2_diff_ff       <= s1_diff_ff;
         s2_peak_ff       <= s1_peak_ff;
      end
      rsp_bullish_ff <= rsp_bullish_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_bullish = rsp_bullish_ff;

endmodule

// File: hw/rtl/double_bottom_pattern_detector.sv
// Double bottom detector on a stream of price samples.
//
// Input channel req_*: one unsigned Q16.16 price per item, with
// req_last_sample marking the final sample of a series. Output channel
// rsp_*: exactly one item per series, sent for its last sample;
// rsp_bullish is 1 when two matching valleys with a high enough peak
// between them were seen in a series of at least MIN_SAMPLES samples.
// Config port csr_*: index 0 is the depth tolerance (Q1.16), index 1 the
// peak margin (Q1.16); write only while the block is idle.
// Throughput: one item per cycle while the queue has room. The result for
// a last sample passes the queue slot, the difference stage, the multiplier
// stage and the result register, and waits there while the receiver stalls.
// A 4-entry job queue sits between the valley finder and the multiplier
// pipe; when the receiver holds rsp_ready low the pipe stalls, the queue
// fills, and req_ready drops once it is full.
// Reset: synchronous; clears the series state, empties the queue and
// restores both config registers to their defaults (0.03 and 1.03).
module double_bottom_pattern_detector #(
   parameter int PRICE_WIDTH = 32,
   parameter int MIN_SAMPLES = 6
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [PRICE_WIDTH-1:0]               req_sample_price,
   input  logic                                 req_last_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_bullish,
   input  logic                                 csr_write_enable,
   input  logic [dbpd_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [dbpd_pkg::CFG_WIDTH-1:0]       csr_write_data
);
   import dbpd_pkg::*;

   localparam int JOB_WIDTH = $bits(job_flags_type) + 3 * PRICE_WIDTH;

   logic                   item_accept;
   logic                   job_push;
   job_flags_type          job_flags;
   logic [PRICE_WIDTH-1:0] job_valley_old;
   logic [PRICE_WIDTH-1:0] job_valley_new;
   logic [PRICE_WIDTH-1:0] job_peak;
   logic [JOB_WIDTH-1:0]   head_data;
   job_flags_type          head_flags;
   logic [PRICE_WIDTH-1:0] head_valley_old;
   logic [PRICE_WIDTH-1:0] head_valley_new;
   logic [PRICE_WIDTH-1:0] head_peak;
   logic                   pop;
   queue_status_type       queue_status;

   // Take an item whenever the queue has room
   assign req_ready   = !queue_status.full;
   assign item_accept = req_valid && req_ready;

   dbpd_front #(
      .PRICE_WIDTH (PRICE_WIDTH),
      .MIN_SAMPLES (MIN_SAMPLES)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .item_accept    (item_accept),
      .sample_price   (req_sample_price),
      .last_sample    (req_last_sample),
      .job_push       (job_push),
      .job_flags      (job_flags),
      .job_valley_old (job_valley_old),
      .job_valley_new (job_valley_new),
      .job_peak       (job_peak)
   );

   dbpd_queue #(
      .WIDTH (JOB_WIDTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data ({job_flags, job_valley_old, job_valley_new, job_peak}),
      .pop       (pop),
      .head_data (head_data),
      .status    (queue_status)
   );

   // Split the queue head back into its fields
   assign {head_flags, head_valley_old, head_valley_new, head_peak} = head_data;

   dbpd_back #(
      .PRICE_WIDTH (PRICE_WIDTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .queue_status     (queue_status),
      .head_flags       (head_flags),
      .head_valley_old  (head_valley_old),
      .head_valley_new  (head_valley_new),
      .head_peak        (head_peak),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_bullish      (rsp_bullish)
   );

`ifndef SYNTHESIS
   // Full and empty never hold together
   a_queue_status: assert property (@(posedge clock) disable iff (reset)
      queue_status.full |-> !queue_status.empty)
      else $error("job queue reports full and empty");

   // A pop from the queue always leaves room for the next cycle
   a_pop_frees: assert property (@(posedge clock) disable iff (reset)
      pop |=> !queue_status.full)
      else $error("job queue still full after a pop");

   // Reset leaves no result pending and the queue drained
   a_reset_clean: assert property (@(posedge clock)
      reset |=> (!rsp_valid && queue_status.empty))
      else $error("state left over after reset");
`endif

endmodule

// File: tb/tb.sv
// Testbench for the double bottom pattern detector: directed and random price series.
module tb;
   import dbpd_pkg::*;

   localparam int PRICE_BITS        = 32;
   localparam int MIN_SERIES        = 6;
   localparam int HALF_PERIOD       = 6;
   localparam int RESET_CYCLES      = 7;
   localparam int DRAIN_CYCLES      = 12;
   localparam int CYCLE_LIMIT       = 400000;
   localparam int IDLE_PERCENT      = 37;
   localparam int SETTING_COUNT     = 8;
   localparam int ITEMS_PER_SETTING = 240;
   localparam int DIRECTED_ROWS     = 24;

   // One directed item; pinned rows carry a verdict read off by hand
   typedef struct packed {
      logic [PRICE_BITS-1:0] price;
      logic                  last;
      logic                  pinned;
      logic                  bullish;
   } directed_row_type;

   logic                       clock            = 1'b0;
   logic                       reset            = 1'b1;
   logic                       req_valid        = 1'b0;
   logic                       req_ready;
   logic [PRICE_BITS-1:0]      req_sample_price = '0;
   logic                       req_last_sample  = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready        = 1'b0;
   logic                       rsp_bullish;
   logic                       csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index        = '0;
   logic [CFG_WIDTH-1:0]       csr_write_data   = '0;

   // Predictor copy of the series state and the registers
   logic [PRICE_BITS-1:0] older_px;
   logic [PRICE_BITS-1:0] newer_px;
   logic [PRICE_BITS-1:0] valley_px;
   logic [PRICE_BITS-1:0] peak_px;
   int unsigned           seen_count;
   logic                  have_valley;
   logic                  found;
   logic [CFG_WIDTH-1:0]  tol_cfg;
   logic [CFG_WIDTH-1:0]  margin_cfg;

   logic                  verdict_due [$];
   logic [PRICE_BITS-1:0] series_q [$];
   logic                  steady = 1'b0;

   int unsigned error_count  = 0;
   int unsigned items_sent   = 0;
   int unsigned results_seen = 0;
   int unsigned bullish_seen = 0;
   int unsigned cycle_count  = 0;

   directed_row_type directed_rows [0:DIRECTED_ROWS-1] = '{
      // lone sample at full scale: too short
      '{32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0},
      // clean double bottom in five samples: still too short
      '{32'h0009_0000, 1'b0, 1'b0, 1'b0},
      '{32'h0001_0000, 1'b0, 1'b0, 1'b0},
      '{32'h0009_0000, 1'b0, 1'b0, 1'b0},
      '{32'h0001_0000, 1'b0, 1'b0, 1'b0},
      '{32'h0009_0000, 1'b1, 1'b1, 1'b0},
      // both valleys at zero under full-scale peaks
      '{32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0},
      '{32'h0000_0000, 1'b0, 1'b0, 1'b0},
      '{32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0},
      '{32'h0000_0000, 1'b0, 1'b0, 1'b0},
      '{32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0},
      '{32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1},
      // steady climb, no valley at all
      '{32'h0001_0000, 1'b0, 1'b0, 1'b0},
      '{32'h0002_0000, 1'b0, 1'b0, 1'b0},
      '{32'h0003_0000, 1'b0, 1'b0, 1'b0},
      '{32'h0004_0000, 1'b0, 1'b0, 1'b0},
      '{32'h0005_0000, 1'b0, 1'b0, 1'b0},
      '{32'h0006_0000, 1'b1, 1'b1, 1'b0},
      // valleys half a point apart, peak just over the default margin
      '{32'h0064_0000, 1'b0, 1'b0, 1'b0},
      '{32'h0032_0000, 1'b0, 1'b0, 1'b0},
      '{32'h0034_0000, 1'b0, 1'b0, 1'b0},
      '{32'h0031_8000, 1'b0, 1'b0, 1'b0},
      '{32'h0035_0000, 1'b0, 1'b0, 1'b0},
      '{32'h0040_0000, 1'b1, 1'b0, 1'b0}
   };

   double_bottom_pattern_detector #(
      .PRICE_WIDTH(PRICE_BITS),
      .MIN_SAMPLES(MIN_SERIES)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample_price (req_sample_price),
      .req_last_sample  (req_last_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_bullish      (rsp_bullish),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #HALF_PERIOD clock = ~clock;

   function automatic void clear_series_state();
      older_px    = '0;
      newer_px    = '0;
      valley_px   = '0;
      peak_px     = '0;
      seen_count  = 0;
      have_valley = 1'b0;
      found       = 1'b0;
   endfunction

   // Advance the series by one sample; returns 1 when a verdict is due
   function automatic logic advance_series(input logic [PRICE_BITS-1:0] px,
                                           input logic last_px,
                                           output logic bullish_out);
      logic [PRICE_BITS-1:0] hi_v;
      logic [PRICE_BITS-1:0] diff_v;
      logic                  depth_ok;
      logic                  peak_ok;
      bullish_out = 1'b0;
      if (seen_count >= 2) begin
         // carry the running peak since the last valley
         if (have_valley && newer_px > peak_px) peak_px = newer_px;
         // middle sample strictly below both neighbors: a valley
         if (newer_px < older_px && newer_px < px) begin
            if (have_valley) begin
               hi_v     = (valley_px > newer_px) ? valley_px : newer_px;
               diff_v   = (valley_px > newer_px) ? valley_px - newer_px : newer_px - valley_px;
               depth_ok = ({32'd0, diff_v} << FRAC_BITS) <= 64'(hi_v) * 64'(tol_cfg);
               peak_ok  = 64'(hi_v) * 64'(margin_cfg) <= ({32'd0, peak_px} << FRAC_BITS);
               if (depth_ok && peak_ok) found = 1'b1;
            end
            have_valley = 1'b1;
            valley_px   = newer_px;
            peak_px     = px;
         end
      end
      older_px = newer_px;
      newer_px = px;
      if (seen_count < MIN_SERIES) seen_count++;
      if (last_px) begin
         bullish_out = found && (seen_count >= MIN_SERIES);
         clear_series_state();
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic logic [63:0] rand_upto(input logic [63:0] span);
      return {32'($urandom), 32'($urandom)} % (span + 64'd1);
   endfunction

   function automatic logic [PRICE_BITS-1:0] to_price(input logic [63:0] x);
      return (x > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : x[PRICE_BITS-1:0];
   endfunction

   // Add one price at the tail of the series being built
   function automatic void append_price(input logic [PRICE_BITS-1:0] px);
      series_q.insert(series_q.size(), px);
   endfunction

   // Offer one item, hold it until accepted, then predict its verdict
   task automatic drive_sample(input logic [PRICE_BITS-1:0] px, input logic last_px,
                               input logic pinned, input logic pinned_bullish);
      logic predicted;
      logic due;
      while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_sample_price <= px;
      req_last_sample  <= last_px;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      due = advance_series(px, last_px, predicted);
      if (due) verdict_due.insert(verdict_due.size(), pinned ? pinned_bullish : predicted);
      items_sent++;
      @(negedge clock);
   endtask

   // Drop valid and wait out every verdict plus the pipe depth
   task automatic settle();
      req_valid <= 1'b0;
      while (verdict_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Write both registers on consecutive cycles
   task automatic apply_setting(input logic [CFG_WIDTH-1:0] tol,
                                input logic [CFG_WIDTH-1:0] margin);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_DEPTH_TOLERANCE;
      csr_write_data   <= tol;
      @(negedge clock);
      csr_index        <= CSR_PEAK_MARGIN;
      csr_write_data   <= margin;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      tol_cfg    = tol;
      margin_cfg = margin;
   endtask

   // Build a two- or three-valley series with valleys and peaks near the thresholds
   task automatic build_double_bottom();
      logic [63:0] valley;
      logic [63:0] next_valley;
      logic [63:0] hi_v;
      logic [63:0] peak;
      logic [63:0] step;
      int unsigned valleys;
      series_q.delete();
      valley  = ($urandom_range(0, 19) == 0) ? 64'd0 : 64'($urandom >> $urandom_range(1, 28));
      valleys = $urandom_range(2, 3);
      // lead in from above the first valley
      repeat ($urandom_range(1, 2))
         append_price(to_price(valley + 1 + rand_upto(valley >> 2)));
      for (int k = 0; k < valleys; k++) begin
         append_price(to_price(valley));
         if (k < valleys - 1) begin
            // next valley close to this one, sometimes exactly level
            step = ($urandom_range(0, 3) == 0) ? 64'd0
                                               : rand_upto(valley >> $urandom_range(2, 9));
            next_valley = ($urandom_range(0, 1) == 0) ? valley + step : valley - step;
            hi_v = (valley > next_valley) ? valley : next_valley;
            // rally between the valleys, topping out around the margin
            peak = hi_v + (hi_v >> $urandom_range(2, 7)) + rand_upto(hi_v >> 6) + 1;
            repeat ($urandom_range(0, 2))
               append_price(to_price(hi_v + 1 + rand_upto(peak - hi_v - 1)));
            append_price(to_price(peak));
            repeat ($urandom_range(0, 2))
               append_price(to_price(hi_v + 1 + rand_upto(peak - hi_v - 1)));
            valley = next_valley;
         end
      end
      // recover after the final valley
      repeat ($urandom_range(1, 3))
         append_price(to_price(valley + 1 + rand_upto(valley >> 3)));
   endtask

   // Build a short series of unshaped prices, full range or tightly clustered
   task automatic build_noise();
      int unsigned len;
      logic        narrow;
      series_q.delete();
      len    = $urandom_range(1, 12);
      narrow = 1'($urandom_range(0, 1));
      repeat (len) append_price(narrow ? 32'($urandom_range(0, 7)) : 32'($urandom));
   endtask

   // Receiver stalls at random except in the steady stretch
   always @(negedge clock)
      rsp_ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);

   // Compare each accepted verdict with the oldest one due
   always @(posedge clock) begin : check_verdicts
      logic want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (rsp_bullish) bullish_seen++;
         if (verdict_due.size() == 0) begin
            $error("unexpected result item: bullish %0b", rsp_bullish);
            error_count++;
         end else begin
            want = verdict_due.pop_front();
            if (rsp_bullish !== want) begin
               $error("bullish mismatch: expected %0b, got %0b", want, rsp_bullish);
               error_count++;
            end
         end
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   initial begin
      int unsigned          phase_items;
      int unsigned          pick;
      int unsigned          cut;
      logic [CFG_WIDTH-1:0] tol_pick;
      logic [CFG_WIDTH-1:0] margin_pick;
      clear_series_state();
      tol_cfg    = DEPTH_TOLERANCE_RESET;
      margin_cfg = PEAK_MARGIN_RESET;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed rows under the reset defaults
      foreach (directed_rows[i])
         drive_sample(directed_rows[i].price, directed_rows[i].last,
                      directed_rows[i].pinned, directed_rows[i].bullish);

      for (int s = 0; s < SETTING_COUNT; s++) begin
         settle();
         case (s)
            0: begin tol_pick = DEPTH_TOLERANCE_RESET; margin_pick = PEAK_MARGIN_RESET; end
            1: begin tol_pick = 17'd0;      margin_pick = 17'd65536;  end
            2: begin tol_pick = 17'd65536;  margin_pick = 17'd131071; end
            3: begin tol_pick = 17'd0;      margin_pick = 17'd131071; end
            4: begin tol_pick = 17'd65536;  margin_pick = 17'd65536;  end
            5: begin tol_pick = 17'd131071; margin_pick = 17'd0;      end
            6: begin
               tol_pick    = CFG_WIDTH'($urandom_range(0, 131071));
               margin_pick = CFG_WIDTH'($urandom_range(0, 131071));
            end
            default: begin
               tol_pick    = CFG_WIDTH'($urandom_range(0, 4000));
               margin_pick = CFG_WIDTH'($urandom_range(65536, 70000));
            end
         endcase
         apply_setting(tol_pick, margin_pick);
         steady      = (s == 1);
         phase_items = 0;
         while (phase_items < ITEMS_PER_SETTING) begin
            pick = $urandom_range(0, 99);
            if (pick < 85) begin
               build_double_bottom();
               // cut some series short at a random point
               if (pick >= 70) begin
                  cut = $urandom_range(1, series_q.size());
                  while (series_q.size() > cut) void'(series_q.pop_back());
               end
            end else begin
               build_noise();
            end
            foreach (series_q[i])
               drive_sample(series_q[i], i == series_q.size() - 1, 1'b0, 1'b0);
            phase_items += series_q.size();
         end
      end
      steady = 1'b0;
      settle();

      $display("covered %0d price samples under %0d register settings plus the defaults",
               items_sent, SETTING_COUNT);
      $display("checked %0d series verdicts, %0d bullish, %0d errors",
               results_seen, bullish_seen, error_count);
      if (error_count == 0 && verdict_due.size() == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule

// File: files.f
hw/rtl/dbpd_pkg.sv
hw/rtl/dbpd_front.sv
hw/rtl/dbpd_queue.sv
hw/rtl/dbpd_back.sv
hw/rtl/double_bottom_pattern_detector.sv
tb/tb.sv
